// File: design/uart_rx_with_fifo_defines.svh
// ----------------------------------------------------------------------------
// uart_rx_with_fifo assertion macros
// shared concurrent assertion forms for the uart receiver
// ----------------------------------------------------------------------------
`ifndef UART_RX_WITH_FIFO_DEFINES_SVH
`define UART_RX_WITH_FIFO_DEFINES_SVH

// same-cycle implication, checked out of reset
`define URXF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define URXF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: design/urxf_pkg.sv
// ----------------------------------------------------------------------------
// urxf_pkg
// types and constants shared by the uart receiver modules
// ----------------------------------------------------------------------------
package urxf_pkg;

  localparam int FIFO_DEPTH_DEF = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 2'd1;

  localparam logic [CFG_DATA_W-1:0] FIRST_DELAY_RST = 16'd400;
  localparam logic [CFG_DATA_W-1:0] BIT_PERIOD_RST  = 16'd1250;

  // bit index at which the frame ends (stop bit sample point)
  localparam logic [3:0] STOP_INDEX = 4'd9;

  localparam int AVAIL_W = 7;

  // transaction queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [7:0]         read_data;
    logic               read_valid;
    logic               underflow;
    logic               byte_done;
    logic               overflow;
    logic [AVAIL_W-1:0] available;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_beat_t;

endpackage

// File: design/urxf_ram.sv
// ----------------------------------------------------------------------------
// urxf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module urxf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a same-cycle write to the read address returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/urxf_front.sv
// ----------------------------------------------------------------------------
// urxf_front
// accepts line ticks, runs the bit timer and byte fifo control
// ----------------------------------------------------------------------------
module urxf_front #(
  parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [urxf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [urxf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             accept,
  input  logic                             rx_level,
  input  logic                             pop_req,
  output urxf_pkg::res_beat_t              fe_out
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [15:0]      first_delay_r, bit_period_r;
  logic             line_prev_r, line_prev_nxt;
  logic             receiving_r, receiving_nxt;
  logic [15:0]      tick_count_r, tick_count_nxt;
  logic [3:0]       bit_index_r, bit_index_nxt;
  logic [7:0]       shift_byte_r, shift_byte_nxt;
  logic [PTR_W-1:0] write_ptr_r, write_ptr_nxt;
  logic [PTR_W-1:0] read_ptr_r, read_ptr_nxt;
  logic [CNT_W-1:0] fill_count_r, fill_count_nxt, fill_mid;
  logic             s1_valid_r;

  logic             s1_rvalid_r, s1_under_r, s1_done_r, s1_over_r;
  logic [CNT_W-1:0] s1_fill_r;
  logic [CNT_W+6:0] fill_ext;

  logic        pop_ok, done, push_ok;
  logic [16:0] cnt;
  logic [15:0] limit;
  logic [2:0]  bit_pos;
  logic [7:0]  ram_q;

  always_comb begin
    line_prev_nxt  = rx_level;
    receiving_nxt  = receiving_r;
    tick_count_nxt = tick_count_r;
    bit_index_nxt  = bit_index_r;
    shift_byte_nxt = shift_byte_r;
    write_ptr_nxt  = write_ptr_r;
    read_ptr_nxt   = read_ptr_r;
    done           = 1'b0;
    push_ok        = 1'b0;

    // pop side sees the fifo as it was at the start of the tick
    pop_ok = pop_req && (fill_count_r != '0);
    if (pop_ok) begin
      read_ptr_nxt = (read_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : read_ptr_r + 1'b1;
    end
    fill_mid = fill_count_r - CNT_W'(pop_ok);

    limit   = (bit_index_r == 4'd0) ? first_delay_r : bit_period_r;
    cnt     = {1'b0, tick_count_r} + 17'd1;
    bit_pos = 3'(bit_index_r - 4'd1);

    if (receiving_r) begin
      if (cnt >= {1'b0, limit}) begin
        tick_count_nxt = '0;
        if (bit_index_r == 4'd0) begin
          bit_index_nxt = 4'd1;
        end else if (bit_index_r >= urxf_pkg::STOP_INDEX) begin
          // frame end, stop bit not checked
          done           = 1'b1;
          push_ok        = fill_mid < CNT_W'(FIFO_DEPTH);
          shift_byte_nxt = '0;
          bit_index_nxt  = '0;
          receiving_nxt  = 1'b0;
        end else begin
          shift_byte_nxt[bit_pos] = shift_byte_r[bit_pos] | rx_level;
          bit_index_nxt           = bit_index_r + 4'd1;
        end
      end else begin
        tick_count_nxt = cnt[15:0];
      end
    end else if (line_prev_r && !rx_level) begin
      // falling edge while idle
      receiving_nxt  = 1'b1;
      tick_count_nxt = '0;
      bit_index_nxt  = '0;
      shift_byte_nxt = '0;
    end

    if (push_ok) begin
      write_ptr_nxt = (write_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : write_ptr_r + 1'b1;
    end
    fill_count_nxt = fill_mid + CNT_W'(push_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r <= urxf_pkg::FIRST_DELAY_RST;
      bit_period_r  <= urxf_pkg::BIT_PERIOD_RST;
      line_prev_r   <= 1'b1;
      receiving_r   <= 1'b0;
      tick_count_r  <= '0;
      bit_index_r   <= '0;
      shift_byte_r  <= '0;
      write_ptr_r   <= '0;
      read_ptr_r    <= '0;
      fill_count_r  <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          urxf_pkg::REG_FIRST_DELAY: first_delay_r <= cfg_data;
          urxf_pkg::REG_BIT_PERIOD:  bit_period_r  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        line_prev_r  <= line_prev_nxt;
        receiving_r  <= receiving_nxt;
        tick_count_r <= tick_count_nxt;
        bit_index_r  <= bit_index_nxt;
        shift_byte_r <= shift_byte_nxt;
        write_ptr_r  <= write_ptr_nxt;
        read_ptr_r   <= read_ptr_nxt;
        fill_count_r <= fill_count_nxt;
      end
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rvalid_r <= pop_ok;
      s1_under_r  <= pop_req && !pop_ok;
      s1_done_r   <= done;
      s1_over_r   <= done && !push_ok;
      s1_fill_r   <= fill_count_nxt;
    end
  end

  urxf_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && push_ok),
    .waddr (write_ptr_r),
    .wdata (shift_byte_r),
    .re    (accept && pop_ok),
    .raddr (read_ptr_r),
    .rdata (ram_q)
  );

  assign fill_ext = {7'd0, s1_fill_r};

  always_comb begin
    fe_out.valid          = s1_valid_r;
    fe_out.res.read_data  = s1_rvalid_r ? ram_q : 8'd0;
    fe_out.res.read_valid = s1_rvalid_r;
    fe_out.res.underflow  = s1_under_r;
    fe_out.res.byte_done  = s1_done_r;
    fe_out.res.overflow   = s1_over_r;
    fe_out.res.available  = fill_ext[urxf_pkg::AVAIL_W-1:0];
  end

endmodule

// File: design/urxf_queue.sv
// ----------------------------------------------------------------------------
// urxf_queue
// short result queue decoupling front and back
// ----------------------------------------------------------------------------
module urxf_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  urxf_pkg::res_beat_t           q_in,
  input  logic                          q_pop,
  output urxf_pkg::res_beat_t           q_out,
  output logic [urxf_pkg::QCNT_W-1:0]   q_count
);

  urxf_pkg::res_t                   entry_r [urxf_pkg::QUEUE_DEPTH];
  logic [urxf_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [urxf_pkg::QCNT_W-1:0]      count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_in.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + urxf_pkg::QCNT_W'(q_in.valid) - urxf_pkg::QCNT_W'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_in.valid) begin
      entry_r[wr_ptr_r] <= q_in.res;
    end
  end

  assign q_out.valid = (count_r != '0);
  assign q_out.res   = entry_r[rd_ptr_r];
  assign q_count     = count_r;

endmodule

// File: design/urxf_back.sv
// ----------------------------------------------------------------------------
// urxf_back
// output register stage driving the result channel
// ----------------------------------------------------------------------------
module urxf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  urxf_pkg::res_beat_t  q_head,
  output logic                 q_pop,
  input  logic                 out_stall,
  output logic                 out_valid,
  output urxf_pkg::res_t       out_res
);

  logic           out_valid_r;
  urxf_pkg::res_t out_res_r;
  logic           take;

  // load when empty or when the held transaction leaves this cycle
  assign take  = !out_valid_r || !out_stall;
  assign q_pop = take && q_head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= q_head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res_r <= q_head.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: design/uart_rx_with_fifo.sv
// ----------------------------------------------------------------------------
// uart_rx_with_fifo
// 8n1 uart receiver with a receive byte fifo, one transaction per line tick
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | in_rx_level, in_pop_req
//  out     | output    | out_valid / out_stall| out_read_data .. out_available
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  one input transaction per clock while in_stall is low, one result per input transaction
//  results pass through the front stage + byte ram read, the queue, then the output register
//  rst_n is synchronous; after reset the block accepts at once, no clearing pass
//  in_stall rises once queued transactions plus the one in the front stage
//  take all four queue entries, so out_stall backs up through the queue
//  before it reaches the input
// ----------------------------------------------------------------------------
`include "uart_rx_with_fifo_defines.svh"

module uart_rx_with_fifo #(
  parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [urxf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [urxf_pkg::CFG_DATA_W-1:0]     cfg_data,
  // line tick input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_rx_level,
  input  logic                                in_pop_req,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_read_data,
  output logic                                out_read_valid,
  output logic                                out_underflow,
  output logic                                out_byte_done,
  output logic                                out_overflow,
  output logic [urxf_pkg::AVAIL_W-1:0]        out_available
);

  urxf_pkg::res_beat_t              fe_out;
  urxf_pkg::res_beat_t              q_head;
  urxf_pkg::res_t                   out_res;
  logic [urxf_pkg::QCNT_W-1:0]      q_count;
  logic                             q_pop;
  logic                             in_accept;
  logic [urxf_pkg::QCNT_W:0]        queue_load;

  // registers are always writable
  assign cfg_ready = 1'b1;

  // room is reserved for the transaction already in the front stage
  assign queue_load = {1'b0, q_count} + (urxf_pkg::QCNT_W + 1)'(fe_out.valid);
  assign in_stall   = queue_load >= (urxf_pkg::QCNT_W + 1)'(urxf_pkg::QUEUE_DEPTH);
  assign in_accept  = in_valid && !in_stall;

  // front: bit timer, shifter, byte fifo pointers and store
  urxf_front #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (in_accept),
    .rx_level  (in_rx_level),
    .pop_req   (in_pop_req),
    .fe_out    (fe_out)
  );

  // result queue between front and back
  urxf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_in    (fe_out),
    .q_pop   (q_pop),
    .q_out   (q_head),
    .q_count (q_count)
  );

  // back: output register
  urxf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_read_data  = out_res.read_data;
  assign out_read_valid = out_res.read_valid;
  assign out_underflow  = out_res.underflow;
  assign out_byte_done  = out_res.byte_done;
  assign out_overflow   = out_res.overflow;
  assign out_available  = out_res.available;

  // every accepted tick reaches the front stage register
  `URXF_ASSERT_NEXT(a_accept_to_front, clk, rst_n, in_accept, fe_out.valid)
  // the queue always has room for the front stage transaction
  `URXF_ASSERT_NOW(a_queue_room, clk, rst_n, fe_out.valid,
                   (q_count < urxf_pkg::QCNT_W'(urxf_pkg::QUEUE_DEPTH)) || q_pop)
  // a pop either returns a byte or flags underflow, never both
  `URXF_ASSERT_NOW(a_pop_exclusive, clk, rst_n, out_valid,
                   !(out_read_valid && out_underflow))
  // a dropped byte only comes with a finished frame
  `URXF_ASSERT_NOW(a_overflow_done, clk, rst_n, out_valid && out_overflow, out_byte_done)

endmodule

// File: tb/sv/tb_uart_rx_with_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_rx_with_fifo
// self-checking bench for the 8n1 uart receiver with its receive fifo
// ----------------------------------------------------------------------------
// every input transaction is one line tick; the bench keeps its own copy of
// the receiver and fifo state, works out the result of each accepted tick
// and checks it against the block's output in order; stimulus is a short
// directed part followed by serial frames with random bytes at several baud
// settings, with line noise and broken frames mixed in
// ----------------------------------------------------------------------------
module tb_uart_rx_with_fifo;

  localparam int DEPTH         = urxf_pkg::FIFO_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_CYCLES    = 200000;   // far beyond the slowest correct run
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic rx_level;
    logic pop_req;
  } line_tick_t;

  // dut ports; the inputs are all known from time zero
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [urxf_pkg::CFG_IDX_W-1:0]  cfg_index = urxf_pkg::REG_FIRST_DELAY;
  logic [urxf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_rx_level = 1'b1;
  logic                            in_pop_req = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [7:0]                      out_read_data;
  logic                            out_read_valid;
  logic                            out_underflow;
  logic                            out_byte_done;
  logic                            out_overflow;
  logic [urxf_pkg::AVAIL_W-1:0]    out_available;

  // ticks waiting to be sent and results the block still owes
  line_tick_t     ticks_to_send[$];
  urxf_pkg::res_t due_results[$];
  line_tick_t     next_tick;
  urxf_pkg::res_t want, got;

  // idle percentages of the sender and the receiver
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  // mirrored configuration
  logic [15:0] first_delay_r = urxf_pkg::FIRST_DELAY_RST;
  logic [15:0] bit_period_r  = urxf_pkg::BIT_PERIOD_RST;

  // mirrored receiver and fifo state
  logic        line_prev = 1'b1;
  logic        receiving = 1'b0;
  logic [15:0] tick_cnt = '0;
  logic [3:0]  bit_idx = '0;
  logic [7:0]  shift_byte = '0;
  logic [7:0]  byte_store [DEPTH];
  int          wr_ptr = 0;
  int          rd_ptr = 0;
  int          fill_cnt = 0;

  uart_rx_with_fifo dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_level    (in_rx_level),
    .in_pop_req     (in_pop_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_read_valid (out_read_valid),
    .out_underflow  (out_underflow),
    .out_byte_done  (out_byte_done),
    .out_overflow   (out_overflow),
    .out_available  (out_available)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // advance the mirrored receiver by one line tick and return its result
  function automatic urxf_pkg::res_t step_receiver(input logic lvl, input logic pop);
    urxf_pkg::res_t r;
    logic [15:0]    lim;
    logic [16:0]    cnt;
    r = '0;
    // pop is served first, from the fifo as it stood at the start of the tick
    if (pop) begin
      if (fill_cnt > 0) begin
        r.read_data  = byte_store[rd_ptr];
        r.read_valid = 1'b1;
        rd_ptr       = (rd_ptr + 1) % DEPTH;
        fill_cnt     = fill_cnt - 1;
      end else begin
        r.underflow = 1'b1;
      end
    end
    if (receiving) begin
      // a limit of zero behaves like one since cnt is at least one
      lim = (bit_idx == 0) ? first_delay_r : bit_period_r;
      cnt = {1'b0, tick_cnt} + 17'd1;
      if (cnt >= {1'b0, lim}) begin
        tick_cnt = '0;
        if (bit_idx == 0) begin
          bit_idx = 4'd1;                 // start bit sample, never checked
        end else if (bit_idx >= urxf_pkg::STOP_INDEX) begin
          // frame end: stop bit ignored, store or drop the byte
          r.byte_done = 1'b1;
          if (fill_cnt < DEPTH) begin
            byte_store[wr_ptr] = shift_byte;
            wr_ptr   = (wr_ptr + 1) % DEPTH;
            fill_cnt = fill_cnt + 1;
          end else begin
            r.overflow = 1'b1;
          end
          shift_byte = '0;
          bit_idx    = '0;
          receiving  = 1'b0;
        end else begin
          shift_byte[bit_idx-1] = lvl;    // lsb first
          bit_idx = bit_idx + 4'd1;
        end
      end else begin
        tick_cnt = cnt[15:0];
      end
    end else if (line_prev && !lvl) begin
      // falling edge while idle; the frame-end tick never gets here
      receiving  = 1'b1;
      tick_cnt   = '0;
      bit_idx    = '0;
      shift_byte = '0;
    end
    line_prev   = lvl;
    r.available = fill_cnt[urxf_pkg::AVAIL_W-1:0];
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  function automatic logic pop_roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic push_tick(input logic lvl, input logic pop);
    line_tick_t t;
    t.rx_level = lvl;
    t.pop_req  = pop;
    ticks_to_send.push_back(t);
  endtask

  // ticks from two strings of '0' and '1', line level and pop request
  task automatic push_pattern(input string lv, input string pp);
    for (int i = 0; i < lv.len(); i++)
      push_tick(lv[i] == "1", pp[i] == "1");
  endtask

  // one serial frame at the given effective delays; tick 0 is the falling edge
  // a low stop bit drops the line exactly on the frame-end tick
  task automatic push_frame(input int fd_e, input int bp_e, input logic [7:0] data,
                            input int pop_pct, input bit low_stop, input bit end_pop);
    int   last_t, slot;
    logic lvl;
    last_t = fd_e + urxf_pkg::STOP_INDEX * bp_e;
    for (int t = 0; t <= last_t; t++) begin
      slot = (t <= fd_e) ? 0 : 1 + (t - fd_e - 1) / bp_e;
      if (slot == 0)
        lvl = 1'b0;
      else if (slot >= urxf_pkg::STOP_INDEX)
        lvl = (t == last_t) ? !low_stop : 1'b1;
      else
        lvl = data[slot-1];
      push_tick(lvl, pop_roll(pop_pct) || (end_pop && t == last_t));
    end
  endtask

  // idle line long enough for any frame in progress to finish
  task automatic push_idle(input int n, input int pop_pct);
    repeat (n) push_tick(1'b1, pop_roll(pop_pct));
  endtask

  // an edge and then random line levels, for settings too slow for whole frames
  task automatic push_noise(input int n, input int pop_pct);
    push_tick(1'b1, pop_roll(pop_pct));
    push_tick(1'b0, pop_roll(pop_pct));
    repeat (n) push_tick(1'($urandom_range(1)), pop_roll(pop_pct));
  endtask

  // well-formed frames with random bytes, some noise and broken frames between
  task automatic send_frames(input int n_frames, input int pop_pct,
                             input int noise_pct, input bit end_pop);
    int fd_e, bp_e, span;
    fd_e = (first_delay_r == 0) ? 1 : first_delay_r;
    bp_e = (bit_period_r == 0) ? 1 : bit_period_r;
    span = fd_e + urxf_pkg::STOP_INDEX * bp_e + 1;
    push_idle(span, pop_pct);
    for (int f = 0; f < n_frames; f++) begin
      if ($urandom_range(99) < noise_pct) begin
        if ($urandom_range(1)) begin
          repeat ($urandom_range(1, 12))
            push_tick(1'($urandom_range(1)), pop_roll(pop_pct));
        end else begin
          // line low on the frame-end tick and after: no new frame starts
          push_frame(fd_e, bp_e, 8'($urandom), pop_pct, 1'b1, 1'b0);
          push_tick(1'b0, pop_roll(pop_pct));
        end
        push_idle(span, pop_pct);
      end
      push_idle($urandom_range(1), pop_pct);
      push_frame(fd_e, bp_e, 8'($urandom), pop_pct, 1'b0, end_pop);
    end
  endtask

  // wait until every tick is sent and every result has come back
  task automatic wait_drained;
    while (ticks_to_send.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers back to back, only while nothing is in flight
  task automatic write_config(input logic [15:0] fd, input logic [15:0] bp);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= urxf_pkg::REG_FIRST_DELAY;
    cfg_data  <= fd;
    do @(posedge clk); while (!cfg_ready);
    first_delay_r = fd;
    cfg_index <= urxf_pkg::REG_BIT_PERIOD;
    cfg_data  <= bp;
    do @(posedge clk); while (!cfg_ready);
    bit_period_r = bp;
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // driver: one line tick per transaction, held while stalled
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      // accepted tick: work out what the block must answer
      if (in_valid && !in_stall)
        due_results.push_back(step_receiver(in_rx_level, in_pop_req));
      if (!in_valid || !in_stall) begin
        if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_tick = ticks_to_send.pop_front();
          in_valid    <= 1'b1;
          in_rx_level <= next_tick.rx_level;
          in_pop_req  <= next_tick.pop_req;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // monitor: compare every accepted result with the oldest one owed
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.read_data  = out_read_data;
        got.read_valid = out_read_valid;
        got.underflow  = out_underflow;
        got.byte_done  = out_byte_done;
        got.overflow   = out_overflow;
        got.available  = out_available;
        if (due_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: result with nothing owed: data=%h rv=%b uf=%b bd=%b of=%b av=%0d",
                     $realtime, got.read_data, got.read_valid, got.underflow,
                     got.byte_done, got.overflow, got.available);
        end else begin
          want = due_results.pop_front();
          if (got.read_data !== want.read_data || got.read_valid !== want.read_valid ||
              got.underflow !== want.underflow || got.byte_done !== want.byte_done ||
              got.overflow !== want.overflow || got.available !== want.available) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display({"%0t: mismatch exp data=%h rv=%b uf=%b bd=%b of=%b av=%0d,",
                        " got data=%h rv=%b uf=%b bd=%b of=%b av=%0d"},
                       $realtime, want.read_data, want.read_valid, want.underflow,
                       want.byte_done, want.overflow, want.available,
                       got.read_data, got.read_valid, got.underflow,
                       got.byte_done, got.overflow, got.available);
          end
        end
      end
      // receiver back-pressure
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------------
  initial begin
    // synchronous reset, applied once
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles about a third of the time, receiver stalls about half
    send_idle_pct = 36;
    recv_idle_pct = 52;

    // reset settings: pop on empty fifo, falling edge, another empty pop
    push_pattern("1001", "1010");

    // zero limits act as one: the open frame finishes with 0xa5, the line
    // drops on the frame-end tick and is not taken as an edge, the byte is
    // popped, then a frame of all ones ends on a pop of an empty fifo
    write_config(16'd0, 16'd0);
    push_pattern("01010010100101111111111", "00000000001000000000001");

    // widest settings: only the start of a frame is reached
    write_config(16'hFFFF, 16'hFFFF);
    push_noise(40, 20);

    // fastest baud with no pops: fill the fifo, then overflow
    write_config(16'd1, 16'd1);
    send_frames(68, 0, 0, 1'b0);
    // pop on the frame-end tick of a full fifo makes room for the push
    send_frames(2, 0, 0, 1'b1);

    // swap the idle rates, drain with heavy popping into underflow
    write_config(16'd2, 16'd1);
    send_idle_pct = 52;
    recv_idle_pct = 36;
    send_frames(20, 60, 15, 1'b0);

    // short first delay, longest bit period
    write_config(16'd1, 16'hFFFF);
    push_noise(30, 30);

    // no idling from here on
    write_config(16'd3, 16'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_frames(6, 10, 20, 1'b0);

    write_config(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)));
    send_frames(10, 15, 15, 1'b0);

    wait_drained();
    if (mismatch_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: uart_rx_with_fifo.f
+incdir+design
design/urxf_pkg.sv
design/urxf_ram.sv
design/urxf_front.sv
design/urxf_queue.sv
design/urxf_back.sv
design/uart_rx_with_fifo.sv
tb/sv/tb_uart_rx_with_fifo.sv
